// File: rtl/ctfp_pkg.sv
// ctfp_pkg: command codes, frame identifiers, scale gains and CRC-8 helpers
// for the CAN telemetry frame packer. No dependencies.
`default_nettype none

package ctfp_pkg;

	typedef enum logic [2:0] {
		CMD_CONTROL  = 3'd0,
		CMD_ACCEL    = 3'd1,
		CMD_RATE     = 3'd2,
		CMD_VELOCITY = 3'd3,
		CMD_EULER    = 3'd4
	} cmd_t;

	localparam logic [10:0] ID_CONTROL  = 11'h500;
	localparam logic [10:0] ID_ACCEL    = 11'h503;
	localparam logic [10:0] ID_RATE     = 11'h504;
	localparam logic [10:0] ID_VELOCITY = 11'h505;
	localparam logic [10:0] ID_EULER    = 11'h506;

	// Q16.16 value times gain, then >> 16 with rounding, gives the frame count
	localparam int          GAIN_W       = 14;
	localparam int          PROD_W       = 32 + GAIN_W;
	localparam logic [GAIN_W-1:0] GAIN_CONTROL = 14'd10000;
	localparam logic [GAIN_W-1:0] GAIN_CENTI   = 14'd100;
	localparam logic [GAIN_W-1:0] GAIN_RATE    = 14'd500;
	localparam logic [GAIN_W-1:0] GAIN_EULER   = 14'd10000;

	localparam logic [15:0] CTRL_MAX  = 16'd10000;
	localparam logic [15:0] PHYS_MAX  = 16'h7FFF;
	localparam logic [15:0] PHYS_MIN  = 16'h8000;

	// CRC-8 SAE-J1850
	localparam logic [7:0] CRC_POLY   = 8'h1D;
	localparam logic [7:0] CRC_INIT   = 8'hFF;
	localparam logic [7:0] CRC_XOROUT = 8'hFF;
	localparam int         CRC_BITS   = 56;
	localparam int         CTRL_CRC_BYTES = 5;
	localparam int         PHYS_CRC_BYTES = 7;

	typedef logic [7:0] crc_cols_t [CRC_BITS];

	// Bit-serial CRC register update; only evaluated on constants.
	function automatic logic [7:0] crc_run(logic [CRC_BITS-1:0] d, int nbytes,
		logic [7:0] init);
		logic [7:0] c;
		c = init;
		for (int i = 0; i < nbytes; i++) begin
			c = c ^ d[8*i +: 8];
			for (int b = 0; b < 8; b++) begin
				if (c[7]) begin
					c = {c[6:0], 1'b0} ^ CRC_POLY;
				end else begin
					c = {c[6:0], 1'b0};
				end
			end
		end
		return c;
	endfunction

	// The CRC is affine in the data: column j is the contribution of data bit j.
	function automatic crc_cols_t crc_columns(int nbytes);
		crc_cols_t cols;
		for (int j = 0; j < CRC_BITS; j++) begin
			if (j < 8 * nbytes) begin
				cols[j] = crc_run(CRC_BITS'(1) << j, nbytes, 8'h00);
			end else begin
				cols[j] = 8'h00;
			end
		end
		return cols;
	endfunction

	localparam crc_cols_t  CRC_COLS_CTRL = crc_columns(CTRL_CRC_BYTES);
	localparam crc_cols_t  CRC_COLS_PHYS = crc_columns(PHYS_CRC_BYTES);
	localparam logic [7:0] CRC_BASE_CTRL =
		crc_run('0, CTRL_CRC_BYTES, CRC_INIT) ^ CRC_XOROUT;
	localparam logic [7:0] CRC_BASE_PHYS =
		crc_run('0, PHYS_CRC_BYTES, CRC_INIT) ^ CRC_XOROUT;

	// Runtime CRC: an XOR tree over the data bits.
	function automatic logic [7:0] crc_fold(logic [CRC_BITS-1:0] d, crc_cols_t cols,
		logic [7:0] base);
		logic [7:0] c;
		c = base;
		for (int j = 0; j < CRC_BITS; j++) begin
			c = c ^ (d[j] ? cols[j] : 8'h00);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/can_telemetry_frame_packer.sv
// can_telemetry_frame_packer: builds one 8-byte CAN frame per request.
// Depends on ctfp_pkg (codes, gains, CRC columns).
//
//  channel | direction | handshake            | fields
//  in      | input     | in_valid / in_ready  | command, first_value, second_value,
//          |           |                      | third_value
//  out     | output    | out_valid/out_ready  | frame_id, payload
//
// Two registers: input and result. Scaling, clamps, packing and CRC sit between them.
// One request per cycle sustained while out_ready is high; a taken request passes
// from the input register to the result register. in_ready drops only while both
// registers are full and out_ready is low.
// Reset clears both valid bits and both rolling counters.
// Commands 5 to 7 are accepted and dropped; they produce no frame.
`default_nettype none

module can_telemetry_frame_packer (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [2:0]              command,
	input  wire logic signed [31:0]      first_value,
	input  wire logic signed [31:0]      second_value,
	input  wire logic signed [31:0]      third_value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [10:0]                  frame_id,
	output logic [63:0]                  payload
);

	import ctfp_pkg::*;

	// stage enables
	logic en_s1, en_out;

	// stage 1: input register
	logic              v_s1;
	cmd_t              cmd_s1;
	logic signed [31:0] val_s1 [3];

	// result register
	logic              out_valid_q;
	logic [10:0]       frame_id_q;
	logic [63:0]       payload_q;

	// rolling counters
	logic [3:0]        alive_q;
	logic [7:0]        group_q;

	logic              in_known;
	logic              is_ctrl;
	logic [GAIN_W-1:0] gain;
	logic [31:0]       mag [3];
	logic [PROD_W-1:0] prod [3];
	logic [15:0]       cnt [3];
	logic [63:0]       data_next;
	logic [10:0]       id_next;
	logic [7:0]        crc;
	logic [63:0]       payload_next;

	assign en_out   = !out_valid_q || out_ready;
	assign en_s1    = !v_s1 || en_out;
	assign in_ready = en_s1;
	assign in_known = (command <= CMD_EULER);
	assign is_ctrl  = (cmd_s1 == CMD_CONTROL);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid && in_known;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid && in_known) begin
			cmd_s1    <= cmd_t'(command);
			val_s1[0] <= first_value;
			val_s1[1] <= second_value;
			val_s1[2] <= third_value;
		end
	end

	// ---------------------------------------------------------- frame build
	// Round half up on the magnitude, then clamp. A negative control fraction
	// always lands at zero; negative physics values round away from zero.
	function automatic logic [15:0] lane_count(logic ctrl, logic neg,
		logic [PROD_W-1:0] p);
		logic [PROD_W:0]    t;
		logic [PROD_W-16:0] r;
		logic [15:0]        c;
		t = {1'b0, p} + (PROD_W + 1)'(32768);
		r = t[PROD_W:16];
		if (ctrl) begin
			if (neg) begin
				c = 16'd0;
			end else if (r > (PROD_W - 15)'(CTRL_MAX)) begin
				c = CTRL_MAX;
			end else begin
				c = r[15:0];
			end
		end else if (neg) begin
			if (r > (PROD_W - 15)'(PHYS_MIN)) begin
				c = PHYS_MIN;
			end else begin
				c = ~r[15:0] + 16'd1;
			end
		end else if (r > (PROD_W - 15)'(PHYS_MAX)) begin
			c = PHYS_MAX;
		end else begin
			c = r[15:0];
		end
		return c;
	endfunction

	always_comb begin
		unique case (cmd_s1)
			CMD_CONTROL:  gain = GAIN_CONTROL;
			CMD_ACCEL:    gain = GAIN_CENTI;
			CMD_RATE:     gain = GAIN_RATE;
			CMD_VELOCITY: gain = GAIN_CENTI;
			CMD_EULER:    gain = GAIN_EULER;
			default:      gain = GAIN_CENTI;
		endcase
		for (int i = 0; i < 3; i++) begin
			// -2^31 still fits as an unsigned 32-bit magnitude
			mag[i]  = val_s1[i][31] ? (~val_s1[i] + 32'd1) : val_s1[i];
			prod[i] = PROD_W'(mag[i]) * PROD_W'(gain);
			cnt[i]  = lane_count(is_ctrl, val_s1[i][31], prod[i]);
		end
		unique case (cmd_s1)
			CMD_CONTROL:  id_next = ID_CONTROL;
			CMD_ACCEL:    id_next = ID_ACCEL;
			CMD_RATE:     id_next = ID_RATE;
			CMD_VELOCITY: id_next = ID_VELOCITY;
			CMD_EULER:    id_next = ID_EULER;
			default:      id_next = ID_CONTROL;
		endcase
		if (is_ctrl) begin
			data_next = {24'h0, 3'b000, alive_q, 1'b1, cnt[1], cnt[0]};
		end else begin
			data_next = {8'h00, group_q, cnt[2], cnt[1], cnt[0]};
		end
	end

	assign crc = is_ctrl ? crc_fold(data_next[CRC_BITS-1:0], CRC_COLS_CTRL, CRC_BASE_CTRL)
	                     : crc_fold(data_next[CRC_BITS-1:0], CRC_COLS_PHYS, CRC_BASE_PHYS);

	assign payload_next = is_ctrl ? {data_next[63:48], crc, data_next[39:0]}
	                              : {crc, data_next[55:0]};

	// ---------------------------------------------------------- result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			alive_q     <= 4'd0;
			group_q     <= 8'd0;
		end else if (en_out) begin
			out_valid_q <= v_s1;
			if (v_s1 && is_ctrl) begin
				alive_q <= alive_q + 4'd1;
			end
			if (v_s1 && cmd_s1 == CMD_EULER) begin
				group_q <= group_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s1) begin
			frame_id_q <= id_next;
			payload_q  <= payload_next;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_id  = frame_id_q;
	assign payload   = payload_q;

endmodule

`default_nettype wire
